// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/hfr_pkg.sv =====
// ----------------------------------------------------------------------------
// hfr_pkg
// Constants, codes and hex decode helpers of the hex frame receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

  localparam int BUFFER_CHARS = 64;
  localparam int POS_W        = $clog2(BUFFER_CHARS + 1);
  localparam int PAYLOAD_N    = 6;
  localparam int PADDR_W      = 5;

  // ASCII bounds of the hex digits
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;

  // Register indexes
  localparam logic [2:0] REG_START_CHAR   = 3'd0;
  localparam logic [2:0] REG_END_CHAR     = 3'd1;
  localparam logic [2:0] REG_COMMAND_CHAR = 3'd2;
  localparam logic [2:0] REG_PING_CHAR    = 3'd3;
  localparam logic [2:0] REG_SYNC_ADDR    = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_START_CHAR   = 8'd1;
  localparam logic [7:0] RST_END_CHAR     = 8'd2;
  localparam logic [7:0] RST_COMMAND_CHAR = 8'd67;
  localparam logic [7:0] RST_PING_CHAR    = 8'd80;
  localparam logic [7:0] RST_SYNC_ADDR    = 8'd255;

  // Status codes
  localparam logic [2:0] ST_WAITING   = 3'd0;
  localparam logic [2:0] ST_PENDING   = 3'd1;
  localparam logic [2:0] ST_OK        = 3'd2;
  localparam logic [2:0] ST_BAD_FRAME = 3'd3;
  localparam logic [2:0] ST_BAD_CS    = 3'd4;
  localparam logic [2:0] ST_UNHANDLED = 3'd5;

  // Event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_CMD  = 2'd1;
  localparam logic [1:0] EV_SYNC = 2'd2;
  localparam logic [1:0] EV_PING = 2'd3;

  typedef struct packed {
    logic [7:0]  ping_value;
    logic [7:0]  cmd_addr;
    logic [15:0] cmd_word;
    logic [1:0]  event_res;
    logic [2:0]  status;
  } result_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      d = c - CHAR_A + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    return {nibble_of(hi), nibble_of(lo)};
  endfunction

endpackage

// ===== hdl/hex_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// hex_frame_receiver_core
// Parses hex-coded frames one character per beat and reports a status word
// with the decoded command, sync or ping fields for every character.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  rx_char
//   m_axis    out  m_axis_tvalid / m_axis_tready  status, event_res, fields
//   apb       in   psel, penable, pwrite, pready  5 byte-wide registers
//
// One beat per cycle while s_axis_tready is high: the frame parser updates
// its state and builds the result in the cycle a beat is taken; the result
// is registered. An output register plus a skid register decouple the stall
// path, so s_axis_tready depends only on the skid register.
// rst_ni clears the parser state and both output slots, resets the registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_frame_receiver_core
  import hfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // rx_char [7:0]
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // cmd_word [15:0], cmd_addr [23:16], ping_value [31:24]
  output logic [31:0]        m_axis_tdata,
  // status [2:0], event_res [4:3]
  output logic [4:0]         m_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] start_char_q, end_char_q, command_char_q, ping_char_q, sync_addr_q;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q   <= RST_START_CHAR;
      end_char_q     <= RST_END_CHAR;
      command_char_q <= RST_COMMAND_CHAR;
      ping_char_q    <= RST_PING_CHAR;
      sync_addr_q    <= RST_SYNC_ADDR;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_CHAR:   start_char_q   <= pwdata[7:0];
        REG_END_CHAR:     end_char_q     <= pwdata[7:0];
        REG_COMMAND_CHAR: command_char_q <= pwdata[7:0];
        REG_PING_CHAR:    ping_char_q    <= pwdata[7:0];
        REG_SYNC_ADDR:    sync_addr_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (cfg_idx)
      REG_START_CHAR:   prdata = {24'd0, start_char_q};
      REG_END_CHAR:     prdata = {24'd0, end_char_q};
      REG_COMMAND_CHAR: prdata = {24'd0, command_char_q};
      REG_PING_CHAR:    prdata = {24'd0, ping_char_q};
      REG_SYNC_ADDR:    prdata = {24'd0, sync_addr_q};
      default:          prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame parser state
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      size_q, size_d;
  logic [7:0]       msg_q, msg_d;
  logic [7:0]       pay_q [PAYLOAD_N];
  logic [7:0]       pay_d [PAYLOAD_N];
  logic [7:0]       pay_eff [PAYLOAD_N];
  logic [15:0]      last_q, last_d;
  logic [7:0]       sum_q, sum_d;

  logic             push, pop;
  logic [7:0]       rx;
  result_t          res;

  logic [7:0]       msg_eff, sz, hi, lo, sum_chk, addr_dec;
  logic [15:0]      word_dec, pos_m3;
  logic             in_size, in_body;

  assign rx      = s_axis_tdata;
  assign in_size = (pos_q == POS_W'(1)) || (pos_q == POS_W'(2));
  assign in_body = (pos_q > POS_W'(2)) && (pos_q < POS_W'(BUFFER_CHARS));
  assign msg_eff = (pos_q == POS_W'(3)) ? rx : msg_q;
  assign hi      = last_q[15:8];
  assign lo      = last_q[7:0];
  assign sz      = hex_pair(size_q[15:8], size_q[7:0]);
  assign pos_m3  = {{(16-POS_W){1'b0}}, pos_q} - 16'd3;

  // The current beat stands in for the payload slot it would be written to
  always_comb begin
    for (int k = 0; k < PAYLOAD_N; k++) begin
      pay_eff[k] = (pos_q == POS_W'(4 + k)) ? rx : pay_q[k];
    end
  end

  assign word_dec = {hex_pair(pay_eff[0], pay_eff[1]), hex_pair(pay_eff[2], pay_eff[3])};
  assign addr_dec = hex_pair(pay_eff[4], pay_eff[5]);

  // Drop the two checksum chars from the running sum
  always_comb begin
    sum_chk = sum_q;
    if (pos_q >= POS_W'(4)) sum_chk = sum_chk - lo;
    if (pos_q >= POS_W'(5)) sum_chk = sum_chk - hi;
  end

  always_comb begin
    pos_d  = pos_q;
    size_d = size_q;
    msg_d  = msg_q;
    pay_d  = pay_q;
    last_d = last_q;
    sum_d  = sum_q;

    res            = '0;
    res.status     = ST_PENDING;
    res.event_res  = EV_NONE;

    if (pos_q == '0 && rx == start_char_q) begin
      pos_d  = POS_W'(1);
      last_d = {last_q[7:0], rx};
    end else if (in_size) begin
      if (rx == start_char_q) begin
        // restart the frame
        size_d = '0;
        msg_d  = '0;
        for (int k = 0; k < PAYLOAD_N; k++) pay_d[k] = '0;
        sum_d  = '0;
        pos_d  = POS_W'(1);
        last_d = {8'd0, rx};
      end else if (rx == end_char_q) begin
        pos_d      = '0;
        size_d     = '0;
        msg_d      = '0;
        for (int k = 0; k < PAYLOAD_N; k++) pay_d[k] = '0;
        last_d     = '0;
        sum_d      = '0;
        res.status = ST_BAD_FRAME;
      end else begin
        size_d = {size_q[7:0], rx};
        last_d = {last_q[7:0], rx};
        pos_d  = pos_q + POS_W'(1);
      end
    end else if (in_body) begin
      if (pos_q == POS_W'(3)) msg_d = rx;
      for (int k = 0; k < PAYLOAD_N; k++) begin
        if (pos_q == POS_W'(4 + k)) pay_d[k] = rx;
      end
      pos_d = pos_q + POS_W'(1);
      if (rx == end_char_q) begin
        if ({8'd0, sz} != pos_m3) begin
          res.status = ST_BAD_FRAME;
        end else if (sum_chk != hex_pair(hi, lo)) begin
          res.status = ST_BAD_CS;
        end else if (msg_eff == command_char_q) begin
          if (pos_q >= POS_W'(9)) begin
            res.status = ST_OK;
            if (addr_dec != sync_addr_q) begin
              res.event_res = EV_CMD;
              res.cmd_word  = word_dec;
              res.cmd_addr  = addr_dec;
            end else begin
              res.event_res = EV_SYNC;
            end
          end else begin
            res.status = ST_UNHANDLED;
          end
        end else if (msg_eff == ping_char_q) begin
          if (pos_q >= POS_W'(5)) begin
            res.status     = ST_OK;
            res.event_res  = EV_PING;
            res.ping_value = hex_pair(pay_eff[0], pay_eff[1]);
          end else begin
            res.status = ST_UNHANDLED;
          end
        end else begin
          res.status = ST_OK;
        end
        pos_d  = '0;
        size_d = '0;
        msg_d  = '0;
        for (int k = 0; k < PAYLOAD_N; k++) pay_d[k] = '0;
        last_d = '0;
        sum_d  = '0;
      end else if (rx == start_char_q) begin
        size_d = '0;
        msg_d  = '0;
        for (int k = 0; k < PAYLOAD_N; k++) pay_d[k] = '0;
        sum_d  = '0;
        pos_d  = POS_W'(1);
        last_d = {8'd0, rx};
      end else begin
        sum_d  = sum_q + rx;
        last_d = {last_q[7:0], rx};
      end
    end else begin
      // idle on a non-start char, or buffer overflow: drop and return to idle
      pos_d      = '0;
      size_d     = '0;
      msg_d      = '0;
      for (int k = 0; k < PAYLOAD_N; k++) pay_d[k] = '0;
      last_d     = '0;
      sum_d      = '0;
      res.status = ST_WAITING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      size_q <= '0;
      msg_q  <= '0;
      for (int k = 0; k < PAYLOAD_N; k++) pay_q[k] <= '0;
      last_q <= '0;
      sum_q  <= '0;
    end else if (push) begin
      pos_q  <= pos_d;
      size_q <= size_d;
      msg_q  <= msg_d;
      pay_q  <= pay_d;
      last_q <= last_d;
      sum_q  <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid register
  // --------------------------------------------------------------------------
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign s_axis_tready = ~skid_valid_q;
  assign push          = s_axis_tvalid & s_axis_tready;
  assign pop           = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      // hold the new beat until the output slot frees up
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.ping_value, out_q.cmd_addr, out_q.cmd_word};
  assign m_axis_tuser  = {out_q.event_res, out_q.status};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid full while output empty")
  `ASSERT_IMPLIES(a_pos_in_range, clk_i, rst_ni, 1'b1, pos_q <= POS_W'(BUFFER_CHARS), "position past buffer")
  `ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push && !out_valid_q, out_valid_q, "accepted beat lost")
  `ASSERT_NEXT(a_done_clears, clk_i, rst_ni, push && res.status != ST_PENDING, pos_q == '0, "frame state kept after end")
  `ASSERT_IMPLIES(a_event_only_ok, clk_i, rst_ni, out_valid_q && out_q.event_res != EV_NONE, out_q.status == ST_OK, "event without frame ok")

endmodule

// ===== verif/tb_hex_frame_receiver_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hex_frame_receiver_core
// Self-checking bench for the hex frame receiver. Every character sent gives
// one status report. An in-bench frame tracker predicts each report and the
// report stream is checked field by field. Traffic is mostly well-formed
// command, sync and ping frames with random content. It is mixed with
// corrupted, short, truncated and overflowing frames and line noise. The run
// covers several register settings, random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_hex_frame_receiver_core;
  import hfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_PRINTS  = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic [7:0]         s_axis_tdata = 8'd0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        m_axis_tdata;
  logic [4:0]         m_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  hex_frame_receiver_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register mirror
  logic [7:0] cfg_start = RST_START_CHAR;
  logic [7:0] cfg_end   = RST_END_CHAR;
  logic [7:0] cfg_cmd   = RST_COMMAND_CHAR;
  logic [7:0] cfg_ping  = RST_PING_CHAR;
  logic [7:0] cfg_sync  = RST_SYNC_ADDR;

  // Frame tracker state
  logic [6:0] fr_pos = '0;
  logic [15:0] fr_size = '0;
  logic [7:0] fr_msg = '0;
  logic [7:0] fr_payload [PAYLOAD_N];
  logic [15:0] fr_last2 = '0;
  logic [7:0] fr_sum = '0;

  result_t expected_reports[$];
  result_t want_report;
  logic [7:0] frame_body[$];

  int errors = 0;
  int cycles = 0;
  int chars_sent = 0;
  int reports_seen = 0;
  int settings_used = 0;
  int status_count [8];
  int event_count [4];

  // Pacing knobs
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int rx_mode = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_phase = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycles,
               expected_reports.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Frame tracker
  // ------------------------------------------------------------------------
  function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return c[3:0];
    if (c >= CHAR_A && c <= CHAR_F) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_to_byte(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_digit_value(hi), hex_digit_value(lo)};
  endfunction

  function automatic void clear_frame_state();
    fr_pos = '0;
    fr_size = '0;
    fr_msg = '0;
    foreach (fr_payload[i]) fr_payload[i] = '0;
    fr_last2 = '0;
    fr_sum = '0;
  endfunction

  function automatic void restart_frame(input logic [7:0] b);
    clear_frame_state();
    fr_pos = 7'd1;
    fr_last2 = {8'd0, b};
  endfunction

  function automatic result_t predict_report(input logic [7:0] b);
    result_t r;
    int p;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] sum;
    logic [7:0] addr;
    r = '0;
    r.status = ST_PENDING;
    p = int'(fr_pos);
    if (p == 0 && b == cfg_start) begin
      fr_pos = 7'd1;
      fr_last2 = {fr_last2[7:0], b};
    end else if (p == 1 || p == 2) begin
      if (b == cfg_start) begin
        restart_frame(b);
      end else if (b == cfg_end) begin
        clear_frame_state();
        r.status = ST_BAD_FRAME;
      end else begin
        fr_size = {fr_size[7:0], b};
        fr_last2 = {fr_last2[7:0], b};
        fr_pos = fr_pos + 7'd1;
      end
    end else if (p > 2 && p < BUFFER_CHARS) begin
      if (p == 3) fr_msg = b;
      if (p >= 4 && p <= 9) fr_payload[p-4] = b;
      fr_pos = fr_pos + 7'd1;
      if (b == cfg_end) begin
        hi = fr_last2[15:8];
        lo = fr_last2[7:0];
        sum = fr_sum;
        if (int'(hex_to_byte(fr_size[15:8], fr_size[7:0])) != p - 3) begin
          r.status = ST_BAD_FRAME;
        end else begin
          // Drop the checksum chars themselves from the running sum
          if (p >= 4) sum = sum - lo;
          if (p >= 5) sum = sum - hi;
          if (sum != hex_to_byte(hi, lo)) begin
            r.status = ST_BAD_CS;
          end else if (fr_msg == cfg_cmd) begin
            if (p >= 9) begin
              addr = hex_to_byte(fr_payload[4], fr_payload[5]);
              r.status = ST_OK;
              if (addr != cfg_sync) begin
                r.event_res = EV_CMD;
                r.cmd_word = {hex_to_byte(fr_payload[0], fr_payload[1]),
                              hex_to_byte(fr_payload[2], fr_payload[3])};
                r.cmd_addr = addr;
              end else begin
                r.event_res = EV_SYNC;
              end
            end else begin
              r.status = ST_UNHANDLED;
            end
          end else if (fr_msg == cfg_ping) begin
            if (p >= 5) begin
              r.status = ST_OK;
              r.event_res = EV_PING;
              r.ping_value = hex_to_byte(fr_payload[0], fr_payload[1]);
            end else begin
              r.status = ST_UNHANDLED;
            end
          end else begin
            r.status = ST_OK;
          end
        end
        clear_frame_state();
      end else if (b == cfg_start) begin
        restart_frame(b);
      end else begin
        fr_sum = fr_sum + b;
        fr_last2 = {fr_last2[7:0], b};
      end
    end else begin
      clear_frame_state();
      r.status = ST_WAITING;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Report checker
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < MAX_PRINTS) begin
      $display("[%0t] report %0d: %s got 0x%0h want 0x%0h", $time, reports_seen, what,
               got, want);
    end
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("report with none pending, tuser", m_axis_tuser, 0);
      end else begin
        want_report = expected_reports.pop_front();
        if (m_axis_tuser[2:0] != want_report.status)
          report_mismatch("status", m_axis_tuser[2:0], want_report.status);
        if (m_axis_tuser[4:3] != want_report.event_res)
          report_mismatch("event_res", m_axis_tuser[4:3], want_report.event_res);
        if (m_axis_tdata[15:0] != want_report.cmd_word)
          report_mismatch("cmd_word", m_axis_tdata[15:0], want_report.cmd_word);
        if (m_axis_tdata[23:16] != want_report.cmd_addr)
          report_mismatch("cmd_addr", m_axis_tdata[23:16], want_report.cmd_addr);
        if (m_axis_tdata[31:24] != want_report.ping_value)
          report_mismatch("ping_value", m_axis_tdata[31:24], want_report.ping_value);
        status_count[want_report.status]++;
        if (want_report.status == ST_OK) event_count[want_report.event_res]++;
      end
      reports_seen++;
    end
  end

  // Output stalls, with long holds on request
  always @(negedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    stall_phase = (stall_phase + 1) % 7;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (stall_phase < 4);
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(predict_report(c));
    chars_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
        end
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_START_CHAR:   cfg_start = val;
      REG_END_CHAR:     cfg_end = val;
      REG_COMMAND_CHAR: cfg_cmd = val;
      REG_PING_CHAR:    cfg_ping = val;
      REG_SYNC_ADDR:    cfg_sync = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] idx, input logic [7:0] want);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] != want) report_mismatch("register readback", prdata[7:0], want);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] st, input logic [7:0] en,
                                input logic [7:0] cm, input logic [7:0] pg,
                                input logic [7:0] sy);
    wait_results_drained();
    repeat (3) @(posedge clk_i);
    apb_write(REG_START_CHAR, st);
    apb_write(REG_END_CHAR, en);
    apb_write(REG_COMMAND_CHAR, cm);
    apb_write(REG_PING_CHAR, pg);
    apb_write(REG_SYNC_ADDR, sy);
    apb_read_check(REG_START_CHAR, st);
    apb_read_check(REG_SYNC_ADDR, sy);
    settings_used++;
  endtask

  // ------------------------------------------------------------------------
  // Frame builders
  // ------------------------------------------------------------------------
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_0 + {4'd0, n} : CHAR_A + {4'd0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] rand_body_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 9) < 7) c = nibble_char(4'($urandom_range(0, 15)));
      else c = 8'($urandom_range(0, 255));
    end while (c == cfg_start || c == cfg_end);
    return c;
  endfunction

  function automatic void push_hex_byte(input logic [7:0] v);
    frame_body.push_back(nibble_char(v[7:4]));
    frame_body.push_back(nibble_char(v[3:0]));
  endfunction

  // Body: message char and payload, command or ping shaped
  function automatic void build_good_body(input bit as_ping);
    logic [7:0] addr;
    int extra;
    frame_body.delete();
    if (as_ping) begin
      frame_body.push_back(cfg_ping);
      push_hex_byte(8'($urandom_range(0, 255)));
      extra = $urandom_range(0, 3);
    end else begin
      frame_body.push_back(cfg_cmd);
      push_hex_byte(8'($urandom_range(0, 255)));
      push_hex_byte(8'($urandom_range(0, 255)));
      addr = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) addr = cfg_sync;
      push_hex_byte(addr);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    end
    repeat (extra) frame_body.push_back(rand_body_char());
  endfunction

  // Wrap the body with start, size, checksum and end; send the first cut chars
  task automatic send_frame(input int size_delta, input int cs_delta, input int cut);
    logic [7:0] chars[$];
    logic [7:0] sum;
    logic [7:0] size_byte;
    int n;
    sum = '0;
    foreach (frame_body[i]) sum = sum + frame_body[i];
    sum = sum + 8'(cs_delta);
    size_byte = 8'(frame_body.size() + 2 + size_delta);
    chars.push_back(cfg_start);
    chars.push_back(nibble_char(size_byte[7:4]));
    chars.push_back(nibble_char(size_byte[3:0]));
    foreach (frame_body[i]) chars.push_back(frame_body[i]);
    chars.push_back(nibble_char(sum[7:4]));
    chars.push_back(nibble_char(sum[3:0]));
    chars.push_back(cfg_end);
    n = (cut < 0 || cut > chars.size()) ? chars.size() : cut;
    for (int i = 0; i < n; i++) send_char(chars[i]);
  endtask

  task automatic send_random_frame(input bit vary_pacing);
    int kind;
    int n;
    if (vary_pacing) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_mode = $urandom_range(0, 3);
    end
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      build_good_body(1'b0);
      send_frame(0, 0, -1);
    end else if (kind < 56) begin
      build_good_body(1'b1);
      send_frame(0, 0, -1);
    end else if (kind < 62) begin
      frame_body.delete();
      n = $urandom_range(0, 8);
      repeat (n + 1) frame_body.push_back(rand_body_char());
      send_frame(0, 0, -1);
    end else if (kind < 70) begin
      // Command frame too short to decode, or just long enough
      frame_body.delete();
      frame_body.push_back(cfg_cmd);
      n = $urandom_range(0, 3);
      repeat (n) frame_body.push_back(rand_body_char());
      send_frame(0, 0, -1);
    end else if (kind < 86) begin
      build_good_body($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 3))
        0: send_frame($urandom_range(1, 3) * (($urandom_range(0, 1) == 0) ? 1 : -1), 0, -1);
        1: send_frame(0, $urandom_range(1, 255), -1);
        2: send_frame(0, 0, $urandom_range(1, frame_body.size() + 5));
        default: begin
          send_char(cfg_start);
          if ($urandom_range(0, 1) == 0) send_char(rand_body_char());
          send_char(cfg_end);
        end
      endcase
    end else if (kind < 90) begin
      // Run past the buffer without an end char
      send_char(cfg_start);
      repeat (BUFFER_CHARS + $urandom_range(0, 2)) send_char(rand_body_char());
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_char(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 19) == 0) wait_results_drained();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_register_access();
    apb_read_check(REG_START_CHAR, RST_START_CHAR);
    apb_read_check(REG_END_CHAR, RST_END_CHAR);
    apb_read_check(REG_COMMAND_CHAR, RST_COMMAND_CHAR);
    apb_read_check(REG_PING_CHAR, RST_PING_CHAR);
    apb_read_check(REG_SYNC_ADDR, RST_SYNC_ADDR);
    apply_settings(8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00);
    apb_read_check(REG_END_CHAR, 8'h00);
    apb_read_check(REG_COMMAND_CHAR, 8'hA5);
    apb_read_check(REG_PING_CHAR, 8'h5A);
    apply_settings(RST_START_CHAR, RST_END_CHAR, RST_COMMAND_CHAR, RST_PING_CHAR,
                   RST_SYNC_ADDR);
  endtask

  task automatic test_directed_sequences();
    gaps_on = 1'b1;
    rx_mode = 1;
    // Idle chars, including both extremes
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_A);
    // End char right after start, and after one size char
    send_char(cfg_start);
    send_char(cfg_end);
    send_char(cfg_start);
    send_char(CHAR_0);
    send_char(cfg_end);
    // Start again at index one, then end at index three
    send_char(cfg_start);
    send_char(cfg_start);
    send_char(CHAR_0);
    send_char(CHAR_0);
    send_char(cfg_end);
    // End at index four with a wrong checksum
    send_char(cfg_start);
    send_char(CHAR_0);
    send_char(CHAR_0 + 8'd1);
    send_char(CHAR_0 + 8'd7);
    send_char(cfg_end);
    // Empty frame with a good checksum and an unknown message char
    send_char(cfg_start);
    send_char(CHAR_0);
    send_char(CHAR_0 + 8'd2);
    send_char(CHAR_0);
    send_char(CHAR_0);
    send_char(cfg_end);
  endtask

  task automatic test_random_traffic(input int count);
    int first;
    first = chars_sent;
    while (chars_sent - first < count) send_random_frame(1'b1);
  endtask

  task automatic test_register_extremes();
    apply_settings(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h00);
    test_random_traffic(70);
    apply_settings(8'hFF, 8'h00, "c", "p", 8'h7F);
    test_random_traffic(70);
    apply_settings("<", ">", 8'h00, 8'hFF, 8'hFF);
    test_random_traffic(70);
    apply_settings(8'h7E, 8'h0D, 8'hFF, 8'h00, 8'h00);
    test_random_traffic(70);
  endtask

  task automatic test_register_overlap();
    // Start equals end, command equals ping
    apply_settings("#", "#", "X", "X", 8'h00);
    test_random_traffic(40);
    // Ping char equals end char: a ping frame that ends at index three
    apply_settings(8'h01, "P", "C", "P", 8'hFF);
    send_char(cfg_start);
    send_char(CHAR_0);
    send_char(CHAR_0);
    send_char(cfg_ping);
    test_random_traffic(15);
    // Command char equals end char
    apply_settings(8'h01, "C", "C", "P", 8'hFF);
    send_char(cfg_start);
    send_char(CHAR_0);
    send_char(CHAR_0);
    send_char(cfg_cmd);
    test_random_traffic(15);
  endtask

  task automatic test_random_registers();
    repeat (2) begin
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      test_random_traffic(50);
    end
  endtask

  task automatic test_backpressure_hold();
    int first;
    apply_settings(RST_START_CHAR, RST_END_CHAR, RST_COMMAND_CHAR, RST_PING_CHAR,
                   RST_SYNC_ADDR);
    gaps_on = 1'b0;
    rx_mode = 0;
    hold_requests++;
    first = chars_sent;
    // Keep offering beats while the output is held
    while (chars_sent - first < 40) send_random_frame(1'b0);
    wait_results_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_access();
    test_directed_sequences();
    test_random_traffic(220);
    test_register_extremes();
    test_register_overlap();
    test_random_registers();
    test_backpressure_hold();
    wait_results_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d chars, checked %0d reports under %0d register settings.",
             chars_sent, reports_seen, settings_used);
    $display("ok %0d (cmd %0d sync %0d ping %0d), bad frame %0d, bad sum %0d, %s %0d",
             status_count[ST_OK], event_count[EV_CMD], event_count[EV_SYNC],
             event_count[EV_PING], status_count[ST_BAD_FRAME], status_count[ST_BAD_CS],
             "unhandled", status_count[ST_UNHANDLED]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hfr_pkg.sv
hdl/hex_frame_receiver_core.sv
verif/tb_hex_frame_receiver_core.sv
